// File: sv/bta_pkg.sv
// Package for the binary to ASCII number printer.
// Holds the request codes, character constants, queue entry and back-end state types.
// No dependencies.
package bta_pkg;

  localparam int VAL_W    = 64;
  localparam int NUM_DIG  = 20;
  localparam int BCD_W    = NUM_DIG * 4;
  localparam int REM_W    = 5;
  localparam int CNT_W    = 6;
  localparam int CHAR_W   = 7;
  localparam int ATTR_W   = 8;

  localparam logic [1:0] REQ_SIGNED   = 2'd0;
  localparam logic [1:0] REQ_UNSIGNED = 2'd1;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

  localparam logic [REM_W-1:0] REM_FULL = REM_W'(NUM_DIG);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VAL_W - 1);

  typedef struct packed {
    logic [VAL_W-1:0]  mag;
    logic              neg;
    logic              hex;
    logic [ATTR_W-1:0] attr;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SIGN = 5'b00100,
    S_SKIP = 5'b01000,
    S_EMIT = 5'b10000
  } back_state_t;

  // Maps one digit value to its ASCII character, uppercase for ten and above.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + CHAR_W'(d);
    end else begin
      ch = CH_A + CHAR_W'(d - 4'd10);
    end
    return ch;
  endfunction

endpackage

// File: sv/binary_to_ascii_number_top.sv
// Top level of the binary to ASCII number printer.
// Instantiates bta_front, bta_queue and bta_back; depends on bta_pkg.
//
// Each input item carries a 64-bit value, a format (signed decimal,
// unsigned decimal or uppercase hexadecimal), a 32/64-bit width mode and a
// color attribute. The block returns one result item per character, most
// significant digit first, with a leading '-' for negative signed values,
// no leading zeros, a single '0' for zero, and last_char set on the final
// character; the color attribute rides along on every character. The
// front end classifies an item (masking, sign test and two's-complement
// negation), registers it and hands it through a two-entry queue to the
// back end, so a new item is taken while the previous number still prints.
// The back end takes an item from the queue while idle. It converts
// decimal values with a shift-and-add-3 loop that handles one bit per cycle
// over all 64 bits, emits a '-' for a negative value, steps past each
// suppressed leading zero (up to 19) and emits the digits (up to 20
// characters, sign included). Suppressed zeros and digits always add up
// to 20. A hexadecimal item skips the conversion. Output stalls hold the
// back end; the queue and the front register keep taking items until
// they fill, and then in_ready drops.
module binary_to_ascii_number_top
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_req_type,
  input  logic        in_wide_mode,
  input  logic [7:0]  in_color_attr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_ascii_char,
  output logic [7:0]  out_color_attr_out,
  output logic        out_last_char
);

  // Handshake between the classifier and the queue, and the queue and the
  // converter.
  q_status_t q_status;
  q_entry_t  q_wr_data;
  q_entry_t  q_rd_data;
  logic      q_push;
  logic      q_pop;

  bta_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_req_type   (in_req_type),
    .in_wide_mode  (in_wide_mode),
    .in_color_attr (in_color_attr),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_wr_data     (q_wr_data)
  );

  bta_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // The converter owns the output register, so a waiting character does not
  // block the front end from taking the next item until the queue fills.
  bta_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_status           (q_status),
    .q_rd_data          (q_rd_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ascii_char     (out_ascii_char),
    .out_color_attr_out (out_color_attr_out),
    .out_last_char      (out_last_char)
  );

endmodule

// File: sv/bta_front.sv
// Front end of the number printer: accepts an item and classifies it.
// Depends on bta_pkg for the request codes and the queue entry type.
module bta_front
  import bta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_value,
  input  logic [1:0]        in_req_type,
  input  logic              in_wide_mode,
  input  logic [7:0]        in_color_attr,
  input  q_status_t         q_status,
  output logic              q_push,
  output q_entry_t          q_wr_data
);

  logic       front_valid_r, front_valid_nxt;
  q_entry_t   entry_r, entry_nxt;
  logic [VAL_W-1:0] val_masked;
  logic       sign_bit;
  logic       is_neg;
  logic [VAL_W-1:0] neg_wide;
  logic [31:0] neg_narrow;

  assign q_push    = front_valid_r && !q_status.full;
  assign q_wr_data = entry_r;
  assign in_ready  = !front_valid_r || !q_status.full;

  always_comb begin
    val_masked = in_wide_mode ? in_value : {32'd0, in_value[31:0]};
    sign_bit   = in_wide_mode ? in_value[63] : in_value[31];
    is_neg     = (in_req_type == REQ_SIGNED) && sign_bit;
    neg_wide   = ~in_value + 64'd1;
    neg_narrow = ~in_value[31:0] + 32'd1;
    entry_nxt.neg  = is_neg;
    entry_nxt.hex  = in_req_type[1];
    entry_nxt.attr = in_color_attr;
    if (!is_neg) begin
      entry_nxt.mag = val_masked;
    end else if (in_wide_mode) begin
      entry_nxt.mag = neg_wide;
    end else begin
      entry_nxt.mag = {32'd0, neg_narrow};
    end
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (q_push) begin
      front_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      front_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// File: sv/bta_queue.sv
// Two-entry queue that decouples the front end from the digit back end.
// Depends on bta_pkg for the entry and status types.
module bta_queue
  import bta_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  wr_data,
  input  logic      pop,
  output q_entry_t  rd_data,
  output q_status_t status
);

  q_entry_t    slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign rd_data      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");
`endif

endmodule

// File: sv/bta_back.sv
// Back end of the number printer: bit-serial binary to BCD conversion and
// character emission with leading-zero suppression. Depends on bta_pkg.
module bta_back
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   q_status,
  input  q_entry_t    q_rd_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_ascii_char,
  output logic [7:0]  out_color_attr_out,
  output logic        out_last_char
);

  back_state_t        st_r, st_nxt;
  logic [VAL_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic [ATTR_W-1:0]  attr_r, attr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [ATTR_W-1:0]  out_attr_r;

  logic               slot_free;
  logic               emit;
  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         top_dig;

  assign slot_free          = !out_valid_r || out_ready;
  assign top_dig            = bcd_r[BCD_W-1 -: 4];
  assign out_valid          = out_valid_r;
  assign out_ascii_char     = out_char_r;
  assign out_color_attr_out = out_attr_r;
  assign out_last_char      = out_last_r;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ?
                          bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    st_nxt       = st_r;
    bin_nxt      = bin_r;
    bcd_nxt      = bcd_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    neg_nxt      = neg_r;
    attr_nxt     = attr_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;

    unique case (st_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          q_pop    = 1'b1;
          neg_nxt  = q_rd_data.neg;
          attr_nxt = q_rd_data.attr;
          rem_nxt  = REM_FULL;
          if (q_rd_data.hex) begin
            bcd_nxt = {{(BCD_W-VAL_W){1'b0}}, q_rd_data.mag};
            st_nxt  = S_SKIP;
          end else begin
            bin_nxt = q_rd_data.mag;
            bcd_nxt = '0;
            cnt_nxt = CNT_LAST;
            st_nxt  = S_CONV;
          end
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VAL_W-1]};
        bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          st_nxt = neg_r ? S_SIGN : S_SKIP;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_char_nxt = CH_MINUS;
          out_last_nxt = 1'b0;
          st_nxt       = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_dig == 4'd0 && rem_r != REM_W'(1)) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt = rem_r - REM_W'(1);
        end else begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_char_nxt = digit_char(top_dig);
          out_last_nxt = (rem_r == REM_W'(1));
          bcd_nxt      = {bcd_r[BCD_W-5:0], 4'd0};
          rem_nxt      = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    attr_r     <= attr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (emit) begin
      out_attr_r <= attr_r;
    end
  end

`ifndef SYNTH
  a_conv_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CONV && cnt_r == '0) |=> (bin_r == '0))
    else $error("conversion ended with bits left");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SKIP || st_r == S_EMIT) |-> (rem_r != '0 && rem_r <= REM_FULL))
    else $error("digit count out of range");
`endif

endmodule

// File: test/binary_to_ascii_number_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_to_ascii_number_top: drives numbers through the
// valid/ready input and compares every printed character against a built-in predictor.
// Depends on bta_pkg and the binary_to_ascii_number_top RTL.
module binary_to_ascii_number_top_tb;
  import bta_pkg::*;

  // Format codes beyond the two that the package names. Bit 1 of the
  // format selects hexadecimal, so the unused code prints hexadecimal too.
  localparam logic [1:0] REQ_HEX     = 2'd2;
  localparam logic [1:0] REQ_HEX_ALT = 2'd3;

  // ASCII pieces used by the predictor.
  localparam logic [6:0] CHR_MINUS  = 7'h2D;
  localparam logic [6:0] CHR_ZERO   = 7'h30;
  localparam logic [6:0] LETTER_GAP = 7'd7;

  localparam int RANDOM_ITEMS   = 180;
  localparam int HOLDOFF_AT     = 40;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int CALM_FIRST     = 120;
  localparam int CALM_LAST      = 150;
  localparam int DRAIN_CYCLES   = 200;

  // One number to print, as it goes in on the input channel.
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  req_type;
    logic        wide;
    logic [7:0]  attr;
  } print_req_t;

  // One character as it should come out on the result channel.
  typedef struct packed {
    logic [6:0] ch;
    logic [7:0] attr;
    logic       last;
  } print_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_value;
  logic [1:0]  in_req_type;
  logic        in_wide_mode;
  logic [7:0]  in_color_attr;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  out_ascii_char;
  logic [7:0]  out_color_attr_out;
  logic        out_last_char;

  // Characters still owed by the block, oldest first.
  print_char_t pending_chars[$];

  // Directed table: stimulus plus the text it must print. An empty text
  // means the row is checked against the predictor instead.
  print_req_t directed_reqs[$];
  string      directed_text[$];

  int mismatch_count;
  int accepted_count;
  bit calm;

  binary_to_ascii_number_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value           (in_value),
    .in_req_type        (in_req_type),
    .in_wide_mode       (in_wide_mode),
    .in_color_attr      (in_color_attr),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ascii_char     (out_ascii_char),
    .out_color_attr_out (out_color_attr_out),
    .out_last_char      (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Generous ceiling on the whole run; a hang in the block ends up here.
  initial begin
    #4_000_000;
    $display("binary_to_ascii_number_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Works out the characters one number prints and queues them. The value
  // is trimmed to the selected width, a negative signed value gets a minus
  // sign and is negated within that width, and the magnitude is split into
  // digits least significant first, then emitted most significant first.
  function automatic void predict_number_text(input print_req_t r);
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  digits [0:19];
    logic [6:0]  ch;
    int          n;
    int          k;
    mag  = r.wide ? r.value : {32'd0, r.value[31:0]};
    base = r.req_type[1] ? 64'd16 : 64'd10;
    if (r.req_type == REQ_SIGNED && (r.wide ? mag[63] : mag[31])) begin
      mag = ~mag + 64'd1;
      if (!r.wide) begin
        mag[63:32] = '0;
      end
      pending_chars.push_back('{ch: CHR_MINUS, attr: r.attr, last: 1'b0});
    end
    // A do-while gives zero its single digit for free.
    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      mag       = mag / base;
      n++;
    end while (mag != 64'd0);
    for (k = n - 1; k >= 0; k--) begin
      ch = CHR_ZERO + 7'(digits[k]);
      if (digits[k] > 4'd9) begin
        ch = ch + LETTER_GAP;
      end
      pending_chars.push_back('{ch: ch, attr: r.attr, last: (k == 0)});
    end
  endfunction

  function automatic void add_row(input logic [63:0] value, input logic [1:0] req_type,
                                  input logic wide, input logic [7:0] attr,
                                  input string text);
    directed_reqs.push_back('{value: value, req_type: req_type, wide: wide, attr: attr});
    directed_text.push_back(text);
  endfunction

  // Random values lean toward the interesting corners: small numbers,
  // single set bits, values with the sign bit set, near all-ones and the
  // exact extremes, on top of plain 64-bit noise.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(7))
      0: begin
        v = 64'($urandom_range(99));
      end
      1: begin
        v = 64'd1 << $urandom_range(63);
      end
      2: begin
        v = {$urandom, $urandom} | (($urandom_range(1) != 0) ? 64'h8000_0000_0000_0000
                                                              : 64'h0000_0000_8000_0000);
      end
      3: begin
        v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(20));
      end
      4: begin
        case ($urandom_range(3))
          0:       v = 64'h0000_0000_8000_0000;
          1:       v = 64'h8000_0000_0000_0000;
          2:       v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = {$urandom, 32'h0000_0000};
        endcase
      end
      default: begin
        v = {$urandom, $urandom};
      end
    endcase
    return v;
  endfunction

  // Offers one item and waits for the handshake. Idle cycles go in ahead of
  // the item at random, except in the calm stretch. Valid is only lowered
  // when an idle cycle is actually taken, so it never drops and rises again
  // within the same edge. The expectation is queued at the accepting edge.
  task automatic send_number(input print_req_t r, input string text);
    int j;
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= r.value;
    in_req_type   <= r.req_type;
    in_wide_mode  <= r.wide;
    in_color_attr <= r.attr;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    accepted_count++;
    calm = (accepted_count >= CALM_FIRST) && (accepted_count < CALM_LAST);
    if (text.len() == 0) begin
      predict_number_text(r);
    end else begin
      for (j = 0; j < text.len(); j++) begin
        pending_chars.push_back('{ch: 7'(text[j]), attr: r.attr,
                                  last: (j == text.len() - 1)});
      end
    end
  endtask

  // Stimulus: reset, the directed table, then the random items, then a
  // drain and the verdict.
  initial begin
    print_req_t r;
    int         i;
    mismatch_count = 0;
    accepted_count = 0;
    calm           = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    in_req_type   <= REQ_SIGNED;
    in_wide_mode  <= 1'b0;
    in_color_attr <= '0;

    // Zero in every format, the most negative values, the widest outputs,
    // the unused format code and upper bits that narrow mode must ignore.
    add_row(64'h0, REQ_SIGNED, 1'b0, 8'h00, "0");
    add_row(64'h0, REQ_UNSIGNED, 1'b1, 8'hFF, "0");
    add_row(64'h0, REQ_HEX, 1'b1, 8'h1F, "0");
    add_row(64'h0000_0000_8000_0000, REQ_SIGNED, 1'b0, 8'h07, "-2147483648");
    add_row(64'h8000_0000_0000_0000, REQ_SIGNED, 1'b1, 8'h70, "-9223372036854775808");
    add_row(64'h0000_0000_FFFF_FFFF, REQ_UNSIGNED, 1'b0, 8'hA5, "4294967295");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, REQ_UNSIGNED, 1'b1, 8'h5A, "18446744073709551615");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, REQ_HEX, 1'b1, 8'h3C, "FFFFFFFFFFFFFFFF");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, REQ_HEX, 1'b0, 8'hC3, "FFFFFFFF");
    add_row(64'h0000_0000_FFFF_FFFF, REQ_SIGNED, 1'b0, 8'h81, "-1");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, REQ_SIGNED, 1'b1, 8'h18, "-1");
    add_row(64'hFFFF_FFFF_0000_0000, REQ_SIGNED, 1'b0, 8'h42, "0");
    add_row(64'h1234_5678_9ABC_DEF0, REQ_HEX, 1'b1, 8'h24, "123456789ABCDEF0");
    add_row(64'hFFFF_FFFF_DEAD_BEEF, REQ_HEX_ALT, 1'b0, 8'h99, "DEADBEEF");
    add_row(64'h0000_0000_7FFF_FFFF, REQ_SIGNED, 1'b0, 8'h66, "2147483647");
    add_row(64'h7FFF_FFFF_FFFF_FFFF, REQ_SIGNED, 1'b1, 8'hE7, "9223372036854775807");
    add_row(64'h0000_0000_8000_0000, REQ_UNSIGNED, 1'b0, 8'h0F, "2147483648");
    add_row(64'h1, REQ_HEX, 1'b0, 8'hF0, "1");
    add_row(64'd10, REQ_UNSIGNED, 1'b1, 8'h33, "10");
    add_row(64'hA, REQ_HEX_ALT, 1'b1, 8'hCC, "A");
    add_row(64'hCAFE_F00D_1234_5678, REQ_SIGNED, 1'b1, 8'h55, "");
    add_row(64'h0123_4567_DEAD_BEEF, REQ_SIGNED, 1'b0, 8'hAA, "");
    add_row(64'h0000_0000_0009_FFFF, REQ_UNSIGNED, 1'b1, 8'h01, "");

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed_reqs.size(); i++) begin
      send_number(directed_reqs[i], directed_text[i]);
    end

    // The bulk of the run: random format, width and attribute on shaped
    // values. The output hold-off lands early in this part.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      r.value    = pick_value();
      r.req_type = 2'($urandom_range(3));
      r.wide     = 1'($urandom_range(1));
      r.attr     = 8'($urandom_range(255));
      send_number(r, "");
    end
    in_valid <= 1'b0;

    // Wait for every owed character, then give the block time to show any
    // stray extra character before the verdict.
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("binary_to_ascii_number_top verification clean");
    end else begin
      $display("binary_to_ascii_number_top verification failed");
    end
    $finish;
  end

  // Receiver: stalls at random about 19 times in a hundred, never during the calm
  // stretch, and once holds off for a long run of cycles while the sender
  // keeps offering items, so the queue fills and the input stalls.
  initial begin
    int  holdoff_left;
    bit  holdoff_done;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    out_ready   <= 1'b0;
    forever begin
      @(posedge clk);
      if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 19);
      end
    end
  end

  // Checker: every accepted character is compared field by field with the
  // oldest one still owed.
  always @(posedge clk) begin
    print_char_t exp_char;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_ascii_char));
      end else begin
        exp_char = pending_chars.pop_front();
        if (out_ascii_char !== exp_char.ch) begin
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                    out_ascii_char, exp_char.ch));
        end
        if (out_color_attr_out !== exp_char.attr) begin
          report_mismatch($sformatf("attribute 0x%02h, wanted 0x%02h",
                                    out_color_attr_out, exp_char.attr));
        end
        if (out_last_char !== exp_char.last) begin
          report_mismatch($sformatf("last flag %b, wanted %b on character 0x%02h",
                                    out_last_char, exp_char.last, exp_char.ch));
        end
      end
    end
  end

endmodule
